FILE: rtl/core/mccp_pkg.sv
package mccp_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int SAMPLE_FRAC  = 12;
   localparam int PRICE_W      = 16;
   localparam int LOG_W        = 18;
   localparam int DISC_W       = 17;
   localparam int FRAC_W       = 16;
   localparam int X_W          = 23;
   localparam int TERM_W       = 64;
   localparam int SUM_W        = 64;
   localparam int HALF_W       = 32;
   localparam int MUL_A_W      = 33;
   localparam int MUL_B_W      = 24;
   localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W        = MUL_P_W + HALF_W;
   localparam int QUO_W        = TERM_W - FRAC_W;
   localparam int DIG_PER_CYC  = 8;
   localparam int SDIV_CYCLES  = QUO_W / DIG_PER_CYC;
   localparam int OUT_W        = 32;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 2 * OUT_W;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 18;

   localparam int DEF_TAYLOR_TERMS = 4;
   localparam int DEF_COUNT_BITS   = 32;
   localparam int DEF_QUEUE_DEPTH  = 4;

   localparam logic [TERM_W-1:0] ONE_Q16 = TERM_W'(1) << FRAC_W;

   localparam logic [PRICE_W-1:0]      RST_SPOT      = PRICE_W'(100);
   localparam logic [PRICE_W-1:0]      RST_STRIKE    = PRICE_W'(110);
   localparam logic signed [LOG_W-1:0] RST_DRIFT     = LOG_W'(655);
   localparam logic signed [LOG_W-1:0] RST_DIFFUSION = LOG_W'(13107);
   localparam logic [DISC_W-1:0]       RST_DISCOUNT  = DISC_W'(61720);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SPOT      = 3'd0,
      CSR_STRIKE    = 3'd1,
      CSR_DRIFT     = 3'd2,
      CSR_DIFFUSION = 3'd3,
      CSR_DISCOUNT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PRICE_W-1:0]      spot_price;
      logic [PRICE_W-1:0]      strike_price;
      logic signed [LOG_W-1:0] drift_term;
      logic signed [LOG_W-1:0] diffusion_term;
      logic [DISC_W-1:0]       discount_factor;
   } cfg_type;

   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic                  last;
   } item_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_TERM_LO,
      BK_TERM_HI,
      BK_TERM_DIV,
      BK_ST_LO,
      BK_ST_HI,
      BK_PAYOFF,
      BK_SUM,
      BK_MEAN_DIV,
      BK_PRICE_LO,
      BK_PRICE_HI,
      BK_EMIT
   } back_state_type;

endpackage

FILE: rtl/core/mccp_front.sv
module mccp_front import mccp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  push_valid,
   output item_type              push_item,
   input  logic                  push_ready
);

   logic                         valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0]   z_ff;
   logic                         last_ff;
   logic signed [SAMPLE_W+LOG_W-1:0] prod;
   logic signed [SAMPLE_W+LOG_W-SAMPLE_FRAC-1:0] prod_sh;

   assign req_tready = !valid_ff || push_ready;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         z_ff    <= $signed(req_tdata[SAMPLE_W-1:0]);
         last_ff <= req_tlast;
      end
   end

   // log-return, floor of the Q4.12 scaling
   assign prod    = z_ff * $signed(cfg.diffusion_term);
   assign prod_sh = prod[SAMPLE_W+LOG_W-1:SAMPLE_FRAC];

   assign push_valid     = valid_ff;
   assign push_item.x    = X_W'(prod_sh) + X_W'($signed(cfg.drift_term));
   assign push_item.last = last_ff;

endmodule

FILE: rtl/core/mccp_queue.sv
module mccp_queue import mccp_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic               push, pop;

   assign in_ready  = level_ff != LVL_W'(DEPTH);
   assign out_valid = level_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      level_in = level_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

FILE: rtl/core/mccp_back.sv
module mccp_back import mccp_pkg::*; #(
   parameter int TAYLOR_TERMS = DEF_TAYLOR_TERMS,
   parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W     = $clog2(TAYLOR_TERMS);
   localparam int CNT_W     = $clog2(SUM_W);
   localparam int CNT_EXT_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

   back_state_type               state_ff, state_in;
   logic signed [X_W-1:0]        x_ff, x_in;
   logic                         last_ff, last_in;
   logic signed [TERM_W-1:0]     term_ff, term_in;
   logic signed [TERM_W-1:0]     poly_ff, poly_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         neg_ff, neg_in;
   logic [SUM_W-1:0]             num_ff, num_in;
   logic [COUNT_BITS-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [TERM_W-1:0]     pay_ff, pay_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic                         out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]             price_ff, price_in;
   logic [OUT_W-1:0]             used_ff, used_in;

   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [MUL_P_W-1:0]    mul_p;
   logic [SUM_W:0]               sum_add;
   logic [SUM_W-1:0]             sum_sat;
   logic [SUM_W-1:0]             sum_upd;
   logic [SUM_W-1:0]             sd_num;
   logic [IDX_W-1:0]             sd_rem;
   logic [COUNT_BITS:0]          ld_trial;
   logic                         ld_ge;
   logic [QUO_W-1:0]             quo_n;
   logic signed [QUO_W-1:0]      quo_s;
   logic [CNT_EXT_W-1:0]         cnt_ext;
   logic                         sdiv_done, ldiv_done, last_term, out_free;

   assign sdiv_done = cnt_ff == CNT_W'(SDIV_CYCLES - 1);
   assign ldiv_done = cnt_ff == CNT_W'(SUM_W - 1);
   assign last_term = idx_ff == IDX_W'(TAYLOR_TERMS - 1);
   assign out_free  = !out_valid_ff || rsp_tready;

   // shared multiplier, operands in 32-bit halves
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         BK_TERM_LO: begin
            mul_a = MUL_A_W'({1'b0, term_ff[HALF_W-1:0]});
            mul_b = MUL_B_W'(x_ff);
         end
         BK_TERM_HI: begin
            mul_a = MUL_A_W'($signed(term_ff[TERM_W-1:HALF_W]));
            mul_b = MUL_B_W'(x_ff);
         end
         BK_ST_LO: begin
            mul_a = MUL_A_W'({1'b0, poly_ff[HALF_W-1:0]});
            mul_b = MUL_B_W'({1'b0, cfg.spot_price});
         end
         BK_ST_HI: begin
            mul_a = MUL_A_W'($signed(poly_ff[TERM_W-1:HALF_W]));
            mul_b = MUL_B_W'({1'b0, cfg.spot_price});
         end
         BK_PRICE_LO: begin
            mul_a = MUL_A_W'({1'b0, num_ff[HALF_W-1:0]});
            mul_b = MUL_B_W'({1'b0, cfg.discount_factor});
         end
         BK_PRICE_HI: begin
            mul_a = MUL_A_W'({1'b0, num_ff[SUM_W-1:HALF_W]});
            mul_b = MUL_B_W'({1'b0, cfg.discount_factor});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // small divisor: several restoring steps a cycle
   always_comb begin
      logic [IDX_W-1:0] r;
      logic [IDX_W:0]   t;
      logic [SUM_W-1:0] d;
      logic             ge;
      r = rem_ff[IDX_W-1:0];
      d = num_ff;
      for (int k = 0; k < DIG_PER_CYC; k++) begin
         t  = {r, d[SUM_W-1]};
         ge = t >= {1'b0, idx_ff};
         t  = ge ? t - {1'b0, idx_ff} : t;
         r  = t[IDX_W-1:0];
         d  = {d[SUM_W-2:0], ge};
      end
      sd_rem = r;
      sd_num = d;
   end

   assign quo_n = sd_num[QUO_W-1:0];
   assign quo_s = neg_ff ? ~quo_n : quo_n;

   // mean: one quotient bit a cycle
   assign ld_trial = {rem_ff, num_ff[SUM_W-1]};
   assign ld_ge    = ld_trial >= {1'b0, count_ff};

   assign sum_add = {1'b0, sum_ff} + {1'b0, pay_ff[SUM_W-1:0]};
   assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
   assign sum_upd = (pay_ff > 0) ? sum_sat : sum_ff;
   assign cnt_ext = CNT_EXT_W'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:     if (q_valid) state_in = BK_TERM_LO;
         BK_TERM_LO:  state_in = BK_TERM_HI;
         BK_TERM_HI:  state_in = BK_TERM_DIV;
         BK_TERM_DIV: if (sdiv_done) state_in = last_term ? BK_ST_LO : BK_TERM_LO;
         BK_ST_LO:    state_in = BK_ST_HI;
         BK_ST_HI:    state_in = BK_PAYOFF;
         BK_PAYOFF:   state_in = BK_SUM;
         BK_SUM:      state_in = last_ff ? BK_MEAN_DIV : BK_IDLE;
         BK_MEAN_DIV: if (ldiv_done) state_in = BK_PRICE_LO;
         BK_PRICE_LO: state_in = BK_PRICE_HI;
         BK_PRICE_HI: state_in = BK_EMIT;
         BK_EMIT:     if (out_free) state_in = BK_IDLE;
         default:     state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      logic [QUO_W-1:0] n;
      n            = '0;
      q_pop        = 1'b0;
      x_in         = x_ff;
      last_in      = last_ff;
      term_in      = term_ff;
      poly_in      = poly_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      pay_in       = pay_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      price_in     = price_ff;
      used_in      = used_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               x_in    = q_item.x;
               last_in = q_item.last;
               term_in = ONE_Q16;
               poly_in = ONE_Q16;
               idx_in  = IDX_W'(1);
            end
         end
         BK_TERM_LO, BK_ST_LO, BK_PRICE_LO: begin
            acc_in = ACC_W'(mul_p);
         end
         BK_TERM_HI: begin
            acc_in = acc_ff + (ACC_W'(mul_p) <<< HALF_W);
            // floor divide by i: shift out the scale, divide ~n when negative
            n      = acc_in[TERM_W-1:FRAC_W];
            neg_in = n[QUO_W-1];
            num_in = {(n[QUO_W-1] ? ~n : n), FRAC_W'(0)};
            rem_in = '0;
            cnt_in = '0;
         end
         BK_TERM_DIV: begin
            num_in = sd_num;
            rem_in = COUNT_BITS'(sd_rem);
            cnt_in = cnt_ff + 1'b1;
            if (sdiv_done) begin
               term_in = TERM_W'(quo_s);
               poly_in = poly_ff + TERM_W'(quo_s);
               idx_in  = idx_ff + 1'b1;
            end
         end
         BK_ST_HI, BK_PRICE_HI: begin
            acc_in = acc_ff + (ACC_W'(mul_p) <<< HALF_W);
         end
         BK_PAYOFF: begin
            pay_in = $signed(acc_ff[TERM_W-1:0]
                             - TERM_W'({cfg.strike_price, FRAC_W'(0)}));
         end
         BK_SUM: begin
            sum_in = sum_upd;
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            num_in = sum_upd;
            rem_in = '0;
            cnt_in = '0;
         end
         BK_MEAN_DIV: begin
            rem_in = ld_ge ? COUNT_BITS'(ld_trial - {1'b0, count_ff})
                           : ld_trial[COUNT_BITS-1:0];
            num_in = {num_ff[SUM_W-2:0], ld_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         BK_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               price_in     = (acc_ff[ACC_W-1:FRAC_W+OUT_W] != '0)
                              ? '1 : acc_ff[FRAC_W+OUT_W-1:FRAC_W];
               used_in      = (cnt_ext > CNT_EXT_W'({OUT_W{1'b1}}))
                              ? '1 : cnt_ext[OUT_W-1:0];
               sum_in       = '0;
               count_in     = '0;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      last_ff  <= last_in;
      term_ff  <= term_in;
      poly_ff  <= poly_in;
      idx_ff   <= idx_in;
      neg_ff   <= neg_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      pay_ff   <= pay_in;
      price_ff <= price_in;
      used_ff  <= used_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {used_ff, price_ff};

endmodule

FILE: rtl/core/monte_carlo_call_pricer.sv
// channel   dir  handshake                    payload
// req       in   req_tvalid / req_tready      tdata: normal_sample; tlast: last_sample
// rsp       out  rsp_tvalid / rsp_tready      tdata: option_price, samples_used
// csr       in   csr_valid  / csr_ready       csr_addr, csr_wdata
//
// Front end takes one word a cycle into a QUEUE_DEPTH queue while that queue has room; the back end
// then takes one sample at a time, finishing each before popping the next, paced by its shared 33x24
// multiplier and the 8-bit-a-cycle divider for the series terms.
// A last sample adds the mean divide and two price products.
// Synchronous reset clears sums, counts and queue; no clearing pass.
// A waiting result stalls the back end only when the next result is ready.
module monte_carlo_call_pricer import mccp_pkg::*; #(
   parameter int TAYLOR_TERMS = DEF_TAYLOR_TERMS,
   parameter int COUNT_BITS   = DEF_COUNT_BITS,
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] normal_sample
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] option_price, [63:32] samples_used
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_ready;
   item_type push_item;
   logic     q_valid, q_pop;
   item_type q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_SPOT:      cfg_in.spot_price      = csr_wdata[PRICE_W-1:0];
            CSR_STRIKE:    cfg_in.strike_price    = csr_wdata[PRICE_W-1:0];
            CSR_DRIFT:     cfg_in.drift_term      = $signed(csr_wdata[LOG_W-1:0]);
            CSR_DIFFUSION: cfg_in.diffusion_term  = $signed(csr_wdata[LOG_W-1:0]);
            CSR_DISCOUNT:  cfg_in.discount_factor = csr_wdata[DISC_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spot_price      <= RST_SPOT;
         cfg_ff.strike_price    <= RST_STRIKE;
         cfg_ff.drift_term      <= RST_DRIFT;
         cfg_ff.diffusion_term  <= RST_DIFFUSION;
         cfg_ff.discount_factor <= RST_DISCOUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mccp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   mccp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_item   (push_item),
      .in_ready  (push_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_pop   (q_pop)
   );

   mccp_back #(
      .TAYLOR_TERMS (TAYLOR_TERMS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
